// ----- rtl/core/dp2p_pkg.sv -----
// ----------------------------------------------------------------------------
// dp2p_pkg
// Shared widths, constants and types of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dp2p_pkg;

  // Field widths of one depth pixel
  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;
  localparam int COLOR_BITS = 8;
  localparam int RGB_BITS   = 3 * COLOR_BITS;

  // Input tdata layout, lowest bit first: col, row, depth, red, green, blue
  localparam int IN_COL_LSB    = 0;
  localparam int IN_ROW_LSB    = IN_COL_LSB + COORD_BITS;
  localparam int IN_DEPTH_LSB  = IN_ROW_LSB + COORD_BITS;
  localparam int IN_RED_LSB    = IN_DEPTH_LSB + DEPTH_BITS;
  localparam int IN_GREEN_LSB  = IN_RED_LSB + COLOR_BITS;
  localparam int IN_BLUE_LSB   = IN_GREEN_LSB + COLOR_BITS;
  localparam int IN_FIELDS_W   = IN_BLUE_LSB + COLOR_BITS;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first: x, y, z, packed rgb
  localparam int COORD_OUT_W   = 32;
  localparam int OUT_FIELDS_W  = 3 * COORD_OUT_W + RGB_BITS;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_DATA_W    = 32;
  localparam int CENTER_W      = 16;
  localparam int SCALE_W       = 32;
  localparam int SCALE_HALF_W  = SCALE_W / 2;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_SCALE_X  = 2'd2,
    CFG_SCALE_Y  = 2'd3
  } cfg_index_t;

  localparam logic [CENTER_W-1:0] CENTER_X_RESET = CENTER_W'(8192);
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET = CENTER_W'(6144);

  // Axis datapath widths: |(pix << 4) - center|, times depth, times scale
  localparam int PIX_Q4_W = COORD_BITS + 4;
  localparam int MAG_W    = (PIX_Q4_W > CENTER_W) ? PIX_Q4_W : CENTER_W;
  localparam int DX_W     = MAG_W + 1;
  localparam int M_W      = MAG_W + DEPTH_BITS;
  localparam int A_W      = M_W + SCALE_HALF_W;
  localparam int SUM_W    = A_W + 1;
  localparam int Q_W      = SUM_W - 4;

  // z = round(d * 65536 / 1000) = floor((8192 * d + 62) / 125),
  // done as a multiply by a reciprocal of 125 valid for numerators below 2^30
  localparam int                  ZNUM_W    = DEPTH_BITS + 14;
  localparam int                  ZRECIP_W  = 31;
  localparam logic [ZRECIP_W-1:0] Z_RECIP   = ZRECIP_W'(1099511628);
  localparam int                  Z_SHIFT   = 37;
  localparam int                  ZPROD_W   = ZNUM_W + ZRECIP_W;
  localparam int                  Z_W       = ZPROD_W - Z_SHIFT;
  localparam logic [ZNUM_W-1:0]   Z_ROUND   = ZNUM_W'(62);

  // Pipeline depth and per-stage enables
  localparam int STAGES = 5;
  typedef logic [STAGES-1:0] stage_en_t;

endpackage

`default_nettype wire

// ----- rtl/core/dp2p_axis.sv -----
// ----------------------------------------------------------------------------
// dp2p_axis
// Five-stage projection of one image axis: (pix*16 - center) * d * scale,
// Q.36 down to saturated signed Q16.16, magnitude truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dp2p_axis (
  input  wire logic                                clk,
  input  wire dp2p_pkg::stage_en_t                 en,
  input  wire logic [dp2p_pkg::COORD_BITS-1:0]     pix,
  input  wire logic [dp2p_pkg::CENTER_W-1:0]       center,
  input  wire logic [dp2p_pkg::DEPTH_BITS-1:0]     depth,
  input  wire logic [dp2p_pkg::SCALE_W-1:0]        scale,
  output logic      [dp2p_pkg::COORD_OUT_W-1:0]    coord
);

  logic [dp2p_pkg::DX_W-1:0]        dx;
  logic                             neg1_r, neg2_r, neg3_r, neg4_r;
  logic [dp2p_pkg::MAG_W-1:0]       mag1_r;
  logic [dp2p_pkg::DEPTH_BITS-1:0]  d1_r;
  logic [dp2p_pkg::M_W-1:0]         m2_r;
  logic [dp2p_pkg::A_W-1:0]         a3_r, b3_r;
  logic [dp2p_pkg::SUM_W-1:0]       sum;
  logic [dp2p_pkg::Q_W-1:0]         q4_r;
  logic                             sat_pos, sat_neg;
  logic [dp2p_pkg::COORD_OUT_W-1:0] coord_nxt, coord_r;

  assign dx = dp2p_pkg::DX_W'({pix, 4'b0000}) - dp2p_pkg::DX_W'(center);

  assign sum = dp2p_pkg::SUM_W'(a3_r)
             + dp2p_pkg::SUM_W'(b3_r >> dp2p_pkg::SCALE_HALF_W);

  // Clamp the magnitude to 2^31-1 when positive, to 2^31 when negative
  assign sat_pos = |q4_r[dp2p_pkg::Q_W-1:31];
  assign sat_neg = (|q4_r[dp2p_pkg::Q_W-1:32]) || (q4_r[31] && (|q4_r[30:0]));

  always_comb begin
    if (!neg4_r) begin
      coord_nxt = sat_pos ? 32'h7FFF_FFFF : q4_r[31:0];
    end else begin
      coord_nxt = sat_neg ? 32'h8000_0000 : (32'd0 - q4_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg1_r <= dx[dp2p_pkg::DX_W-1];
      mag1_r <= dx[dp2p_pkg::DX_W-1] ? dp2p_pkg::MAG_W'(-dx) : dp2p_pkg::MAG_W'(dx);
      d1_r   <= depth;
    end
    if (en[1]) begin
      neg2_r <= neg1_r;
      m2_r   <= dp2p_pkg::M_W'(mag1_r) * dp2p_pkg::M_W'(d1_r);
    end
    if (en[2]) begin
      neg3_r <= neg2_r;
      a3_r   <= dp2p_pkg::A_W'(m2_r)
              * dp2p_pkg::A_W'(scale[dp2p_pkg::SCALE_W-1:dp2p_pkg::SCALE_HALF_W]);
      b3_r   <= dp2p_pkg::A_W'(m2_r) * dp2p_pkg::A_W'(scale[dp2p_pkg::SCALE_HALF_W-1:0]);
    end
    if (en[3]) begin
      neg4_r <= neg3_r;
      q4_r   <= sum[dp2p_pkg::SUM_W-1:4];
    end
    if (en[4]) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

`default_nettype wire

// ----- rtl/core/depth_pixel_to_point.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Pinhole back-projection of a depth pixel stream into Q16.16 3-D points.
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock while in_tready is high and returns one
// point per pixel, in order, from the last register stage. The x and y
// multiply chain (offset, times depth, times 32-bit scale in two halves,
// shift, saturate) has one register stage per step; the z path runs beside
// it. Every stage holds its own valid bit and moves up when the stage ahead
// is empty or moving, so bubbles close up and a stalled output does not stop
// input until all five stages are full. A zero depth gives point_valid low
// and all-zero coordinates and colour. Write the cfg registers only while
// the pipeline is empty.
`default_nettype none

module depth_pixel_to_point (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // cfg
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [dp2p_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input pixel stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // pixel_col, pixel_row, depth_mm, red, green, blue
  input  wire logic [dp2p_pkg::IN_TDATA_W-1:0]     in_tdata,
  // color_present
  input  wire logic                                in_tuser,
  // output point stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // point_x, point_y, point_z, packed_rgb
  output logic      [dp2p_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // point_valid
  output logic                                     out_tuser
);

  logic [dp2p_pkg::CENTER_W-1:0]    cx_r, cy_r;
  logic [dp2p_pkg::SCALE_W-1:0]     scale_x_r, scale_y_r;

  logic [dp2p_pkg::COORD_BITS-1:0]  in_col, in_row;
  logic [dp2p_pkg::DEPTH_BITS-1:0]  in_depth;
  logic [dp2p_pkg::RGB_BITS-1:0]    in_rgb;
  logic                             in_pvalid;

  logic [dp2p_pkg::STAGES-1:0]      v_r;
  logic [dp2p_pkg::STAGES-1:0]      rdy;
  dp2p_pkg::stage_en_t              en;
  logic [dp2p_pkg::RGB_BITS-1:0]    rgb_r [dp2p_pkg::STAGES];
  logic [dp2p_pkg::STAGES-1:0]      pv_r;

  logic [dp2p_pkg::ZNUM_W-1:0]      znum1_r;
  logic [dp2p_pkg::ZPROD_W-1:0]     zprod2_r;
  logic [dp2p_pkg::Z_W-1:0]         z3_r, z4_r, z5_r;

  logic [dp2p_pkg::COORD_OUT_W-1:0] point_x, point_y;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= dp2p_pkg::CENTER_X_RESET;
      cy_r      <= dp2p_pkg::CENTER_Y_RESET;
      scale_x_r <= '0;
      scale_y_r <= '0;
    end else if (cfg_we) begin
      case (dp2p_pkg::cfg_index_t'(cfg_index))
        dp2p_pkg::CFG_CENTER_X: cx_r      <= cfg_wdata[dp2p_pkg::CENTER_W-1:0];
        dp2p_pkg::CFG_CENTER_Y: cy_r      <= cfg_wdata[dp2p_pkg::CENTER_W-1:0];
        dp2p_pkg::CFG_SCALE_X:  scale_x_r <= cfg_wdata[dp2p_pkg::SCALE_W-1:0];
        dp2p_pkg::CFG_SCALE_Y:  scale_y_r <= cfg_wdata[dp2p_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction
  assign in_col    = in_tdata[dp2p_pkg::IN_COL_LSB   +: dp2p_pkg::COORD_BITS];
  assign in_row    = in_tdata[dp2p_pkg::IN_ROW_LSB   +: dp2p_pkg::COORD_BITS];
  assign in_depth  = in_tdata[dp2p_pkg::IN_DEPTH_LSB +: dp2p_pkg::DEPTH_BITS];
  assign in_pvalid = |in_depth;
  assign in_rgb    = (in_tuser && in_pvalid)
                   ? {in_tdata[dp2p_pkg::IN_RED_LSB   +: dp2p_pkg::COLOR_BITS],
                      in_tdata[dp2p_pkg::IN_GREEN_LSB +: dp2p_pkg::COLOR_BITS],
                      in_tdata[dp2p_pkg::IN_BLUE_LSB  +: dp2p_pkg::COLOR_BITS]}
                   : '0;

  // A stage advances when it is empty or the stage ahead advances
  always_comb begin
    rdy[dp2p_pkg::STAGES-1] = !v_r[dp2p_pkg::STAGES-1] || out_tready;
    for (int k = dp2p_pkg::STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign en        = rdy;
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < dp2p_pkg::STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Side data: colour and point-valid flag ride along with the stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rgb_r[0] <= in_rgb;
      pv_r[0]  <= in_pvalid;
    end
    for (int k = 1; k < dp2p_pkg::STAGES; k++) begin
      if (en[k]) begin
        rgb_r[k] <= rgb_r[k-1];
        pv_r[k]  <= pv_r[k-1];
      end
    end
  end

  // z path: numerator, reciprocal multiply, take quotient, then hold
  always_ff @(posedge clk) begin
    if (en[0]) begin
      znum1_r <= dp2p_pkg::ZNUM_W'({in_depth, 13'd0}) + dp2p_pkg::Z_ROUND;
    end
    if (en[1]) begin
      zprod2_r <= dp2p_pkg::ZPROD_W'(znum1_r) * dp2p_pkg::ZPROD_W'(dp2p_pkg::Z_RECIP);
    end
    if (en[2]) begin
      z3_r <= zprod2_r[dp2p_pkg::ZPROD_W-1:dp2p_pkg::Z_SHIFT];
    end
    if (en[3]) begin
      z4_r <= z3_r;
    end
    if (en[4]) begin
      z5_r <= z4_r;
    end
  end

  dp2p_axis u_axis_x (
    .clk    (clk),
    .en     (en),
    .pix    (in_col),
    .center (cx_r),
    .depth  (in_depth),
    .scale  (scale_x_r),
    .coord  (point_x)
  );

  dp2p_axis u_axis_y (
    .clk    (clk),
    .en     (en),
    .pix    (in_row),
    .center (cy_r),
    .depth  (in_depth),
    .scale  (scale_y_r),
    .coord  (point_y)
  );

  assign out_tvalid = v_r[dp2p_pkg::STAGES-1];
  assign out_tuser  = pv_r[dp2p_pkg::STAGES-1];
  assign out_tdata  = dp2p_pkg::OUT_TDATA_W'({rgb_r[dp2p_pkg::STAGES-1],
                                              dp2p_pkg::COORD_OUT_W'(z5_r),
                                              point_y,
                                              point_x});

endmodule

`default_nettype wire

// ----- sim/depth_pixel_to_point_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_pixel_to_point_tb
// Self-checking bench for the depth pixel to 3-D point back-projection block.
// ----------------------------------------------------------------------------
// Streams depth pixels into the block and checks every returned point, in
// order, against a fixed-point pinhole predictor that mirrors the camera
// registers. A directed pass covers zero depth, missing colour, saturation
// in both directions and the field extremes. Random pixels follow under a
// series of camera settings, while both stream sides back off at random in all but the last two phases.
// ----------------------------------------------------------------------------

module depth_pixel_to_point_tb;
  import dp2p_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_PIXELS   = 48;
  localparam int SETTLE_CYCLES  = 20;
  // 0.001 / 525 in unsigned Q0.32, a typical depth camera focal length
  localparam logic [SCALE_W-1:0] SCALE_F525 = SCALE_W'(8181);

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_BITS-1:0] depth;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  color_present;
  } pixel_t;

  typedef struct packed {
    logic [COORD_OUT_W-1:0] x;
    logic [COORD_OUT_W-1:0] y;
    logic [COORD_OUT_W-1:0] z;
    logic [RGB_BITS-1:0]    rgb;
    logic                   valid;
  } point_t;

  class point_scoreboard;
    logic [CENTER_W-1:0] ppx_q4;
    logic [CENTER_W-1:0] ppy_q4;
    logic [SCALE_W-1:0]  scale_x;
    logic [SCALE_W-1:0]  scale_y;
    point_t              expected_points[$];
    int unsigned         mismatches;

    function new();
      ppx_q4     = CENTER_X_RESET;
      ppy_q4     = CENTER_Y_RESET;
      scale_x    = '0;
      scale_y    = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_CENTER_X: ppx_q4  = value[CENTER_W-1:0];
        CFG_CENTER_Y: ppy_q4  = value[CENTER_W-1:0];
        CFG_SCALE_X:  scale_x = value[SCALE_W-1:0];
        CFG_SCALE_Y:  scale_y = value[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // (pix * 16 - center) * d * scale, Q.36 down to Q16.16, magnitude truncated
    function logic [COORD_OUT_W-1:0] axis_q16(logic [COORD_BITS-1:0] pix,
                                              logic [CENTER_W-1:0] center,
                                              longint unsigned d,
                                              logic [SCALE_W-1:0] scale);
      longint          offset;
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned q;
      logic [31:0]     q32;
      offset = {pix, 4'b0000};
      offset = offset - center;
      mag    = (offset < 0) ? -offset : offset;
      prod   = mag * d;
      hi     = prod * scale[31:16];
      lo     = prod * scale[15:0];
      q      = (hi + (lo >> 16)) >> 4;
      if (offset >= 0) begin
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
      end
      q32 = q[31:0];
      return -q32;
    endfunction

    function point_t project_pixel(pixel_t p);
      point_t          pt;
      longint unsigned d;
      pt = '0;
      if (p.depth == 0) begin
        return pt;
      end
      d        = p.depth;
      pt.x     = axis_q16(p.col, ppx_q4, d, scale_x);
      pt.y     = axis_q16(p.row, ppy_q4, d, scale_y);
      pt.z     = COORD_OUT_W'(((d << 16) + 500) / 1000);
      pt.rgb   = p.color_present ? {p.red, p.green, p.blue} : '0;
      pt.valid = 1'b1;
      return pt;
    endfunction

    function void note_pixel(pixel_t p);
      expected_points.push_back(project_pixel(p));
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        $error("point returned with no pixel outstanding");
        mismatches++;
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x) begin
        $error("point_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("point_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
        mismatches++;
      end
      if (got.z !== want.z) begin
        $error("point_z: expected %0d, got %0d", $signed(want.z), $signed(got.z));
        mismatches++;
      end
      if (got.rgb !== want.rgb) begin
        $error("packed_rgb: expected 0x%06h, got 0x%06h", want.rgb, got.rgb);
        mismatches++;
      end
      if (got.valid !== want.valid) begin
        $error("point_valid: expected %0b, got %0b", want.valid, got.valid);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  cfg_index_t             cfg_index  = CFG_CENTER_X;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  wire                    in_tready;
  // pixel_col, pixel_row, depth_mm, red, green, blue
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // color_present
  logic                   in_tuser   = 1'b0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  // point_x, point_y, point_z, packed_rgb
  wire  [OUT_TDATA_W-1:0] out_tdata;
  // point_valid
  wire                    out_tuser;

  int unsigned     send_idle_pct = 37;
  int unsigned     recv_idle_pct = 83;
  int unsigned     stall_cycles  = 0;
  point_scoreboard points        = new();

  depth_pixel_to_point uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check results before noting new pixels so a same-edge pair stays ordered
  always @(posedge clk) begin
    pixel_t seen;
    point_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.x     = out_tdata[0 +: COORD_OUT_W];
        got.y     = out_tdata[COORD_OUT_W +: COORD_OUT_W];
        got.z     = out_tdata[2 * COORD_OUT_W +: COORD_OUT_W];
        got.rgb   = out_tdata[3 * COORD_OUT_W +: RGB_BITS];
        got.valid = out_tuser;
        points.check_point(got);
      end
      if (in_tvalid && in_tready) begin
        seen.col           = in_tdata[IN_COL_LSB +: COORD_BITS];
        seen.row           = in_tdata[IN_ROW_LSB +: COORD_BITS];
        seen.depth         = in_tdata[IN_DEPTH_LSB +: DEPTH_BITS];
        seen.red           = in_tdata[IN_RED_LSB +: COLOR_BITS];
        seen.green         = in_tdata[IN_GREEN_LSB +: COLOR_BITS];
        seen.blue          = in_tdata[IN_BLUE_LSB +: COLOR_BITS];
        seen.color_present = in_tuser;
        points.note_pixel(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic pixel_t make_pixel(int unsigned col, int unsigned row,
                                        int unsigned depth, logic [7:0] red,
                                        logic [7:0] green, logic [7:0] blue,
                                        logic present);
    pixel_t p;
    p.col           = COORD_BITS'(col);
    p.row           = COORD_BITS'(row);
    p.depth         = DEPTH_BITS'(depth);
    p.red           = red;
    p.green         = green;
    p.blue          = blue;
    p.color_present = present;
    return p;
  endfunction

  function automatic logic [CENTER_W-1:0] pick_center();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return CENTER_W'($urandom());
      default: return CENTER_W'($urandom_range(40000, 1024));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return SCALE_W'($urandom());
      default: return SCALE_W'($urandom_range(20000, 1000));
    endcase
  endfunction

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({p.blue, p.green, p.red, p.depth, p.row, p.col});
    in_tuser  <= p.color_present;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  // Hold off input and wait until every outstanding point has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (points.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_config(logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                              logic [SCALE_W-1:0] sx, logic [SCALE_W-1:0] sy);
    cfg_index_t            idx;
    logic [CFG_DATA_W-1:0] value;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_index_t'(i);
      case (idx)
        CFG_CENTER_X: value = CFG_DATA_W'(cx);
        CFG_CENTER_Y: value = CFG_DATA_W'(cy);
        CFG_SCALE_X:  value = sx;
        default:      value = sy;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value;
      @(posedge clk);
      points.set_reg(idx, value);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    pixel_t p;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero scales collapse x and y to zero
    send_pixel(make_pixel(0, 0, 1, 8'h00, 8'h00, 8'h00, 1'b1));
    send_pixel(make_pixel(4095, 4095, 65535, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(make_pixel(100, 200, 0, 8'h12, 8'h34, 8'h56, 1'b1));
    drain();

    // Full scale, center at origin: positive saturation
    write_config('0, '0, '1, '1);
    send_pixel(make_pixel(4095, 4095, 65535, 8'hAA, 8'h55, 8'hAA, 1'b1));
    send_pixel(make_pixel(1, 1, 1, 8'h55, 8'hAA, 8'h55, 1'b0));
    send_pixel(make_pixel(0, 0, 65535, 8'h01, 8'h80, 8'h7F, 1'b1));
    send_pixel(make_pixel(4095, 0, 32768, 8'hFE, 8'h01, 8'h80, 1'b1));
    drain();

    // Full scale, center at far corner: negative saturation
    write_config('1, '1, '1, '1);
    send_pixel(make_pixel(0, 0, 65535, 8'hC3, 8'h3C, 8'h99, 1'b1));
    send_pixel(make_pixel(4095, 4095, 1, 8'h00, 8'hFF, 8'h00, 1'b1));
    send_pixel(make_pixel(2048, 1024, 0, 8'hFF, 8'h00, 8'hFF, 1'b0));
    drain();

    // VGA-like camera with a typical focal length
    write_config(CENTER_W'(320 * 16), CENTER_W'(240 * 16), SCALE_F525, SCALE_F525);
    send_pixel(make_pixel(320, 240, 1000, 8'h10, 8'h20, 8'h30, 1'b1));
    send_pixel(make_pixel(0, 0, 1000, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(make_pixel(4095, 4095, 65535, 8'h80, 8'h40, 8'h20, 1'b1));
    send_pixel(make_pixel(639, 479, 500, 8'h55, 8'hAA, 8'h55, 1'b0));
    send_pixel(make_pixel(10, 20, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(make_pixel(1, 2, 65535, 8'h00, 8'h00, 8'h00, 1'b1));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 37;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      write_config(pick_center(), pick_center(), pick_scale(), pick_scale());
      repeat (PHASE_PIXELS) begin
        p.col   = COORD_BITS'($urandom());
        p.row   = COORD_BITS'($urandom());
        case ($urandom_range(9))
          0:       p.depth = '0;
          1:       p.depth = '1;
          2:       p.depth = DEPTH_BITS'($urandom_range(16, 1));
          default: p.depth = DEPTH_BITS'($urandom_range(65535, 1));
        endcase
        p.red           = COLOR_BITS'($urandom());
        p.green         = COLOR_BITS'($urandom());
        p.blue          = COLOR_BITS'($urandom());
        p.color_present = 1'($urandom_range(1));
        send_pixel(p);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (points.mismatches == 0 && points.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
